// File: rtl/lsbf_pkg.sv
// shared types and constants for the least-squares bezier fit block
// no dependencies; imported by every module of the block but lsbf_store

package lsbf_pkg;

    // defaults for the top-level parameters
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // fixed widths of the datapath
    localparam int OUT_BITS  = 48;
    localparam int WIDE_BITS = 128;
    localparam int HALF_BITS = 64;

    typedef logic [WIDE_BITS-1:0] t_wide;
    typedef logic [HALF_BITS-1:0] t_half;
    typedef logic [OUT_BITS-1:0]  t_out;

endpackage

// File: rtl/lsbf_store.sv
// point store: x and y memories, one write port and two registered read ports
// depends on nothing but its parameters

module lsbf_store #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_POINTS)-1:0] i_waddr,
    input  logic [COORD_BITS-1:0]         i_wx,
    input  logic [COORD_BITS-1:0]         i_wy,
    input  logic                          i_re,
    input  logic [$clog2(MAX_POINTS)-1:0] i_raddr_a,
    input  logic [$clog2(MAX_POINTS)-1:0] i_raddr_b,
    output logic [COORD_BITS-1:0]         o_ax,
    output logic [COORD_BITS-1:0]         o_ay,
    output logic [COORD_BITS-1:0]         o_bx,
    output logic [COORD_BITS-1:0]         o_by
);

    logic [COORD_BITS-1:0] r_mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] r_mem_y [MAX_POINTS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wx;
            r_mem_y[i_waddr] <= i_wy;
        end
    end

    // two read ports, data registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_ax <= r_mem_x[i_raddr_a];
            o_ay <= r_mem_y[i_raddr_a];
            o_bx <= r_mem_x[i_raddr_b];
            o_by <= r_mem_y[i_raddr_b];
        end
    end

endmodule

// File: rtl/lsbf_mul.sv
// shared multiplier: wide operand times signed 64-bit operand, modulo 2^128
// eight bits of the short operand per cycle; depends on lsbf_pkg

module lsbf_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lsbf_pkg::t_wide i_a,
    input  lsbf_pkg::t_half i_b,
    output logic           o_done,
    output lsbf_pkg::t_wide o_p
);
    import lsbf_pkg::*;

    localparam int DIGIT = 8;

    logic  r_busy;
    logic  r_fin;
    logic  r_neg;
    t_wide r_a;
    t_wide r_acc;
    t_wide n_acc;
    t_half r_b;
    t_half b_mag;

    // magnitude of the short operand, sign applied at the end
    assign b_mag = i_b[HALF_BITS-1] ? (~i_b) + HALF_BITS'(1) : i_b;
    assign n_acc = r_acc + WIDE_BITS'(r_a * WIDE_BITS'(r_b[DIGIT-1:0]));

    // control: run until the remaining digits are zero, then apply the sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy) begin
                if (r_b[HALF_BITS-1:DIGIT] == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    // datapath: shift-add over digits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= b_mag;
            r_neg <= i_b[HALF_BITS-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= r_a << DIGIT;
            r_b   <= r_b >> DIGIT;
        end else if (r_fin) begin
            o_p <= r_neg ? (~r_acc) + WIDE_BITS'(1) : r_acc;
        end
    end

endmodule

// File: rtl/lsbf_div.sv
// shared divider: round(num * 2^FRAC_BITS / den) to nearest, ties away from zero,
// saturated to the signed output width; one quotient bit per cycle; depends on lsbf_pkg

module lsbf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lsbf_pkg::t_wide i_num,
    input  lsbf_pkg::t_wide i_den,
    output logic            o_done,
    output lsbf_pkg::t_out  o_q
);
    import lsbf_pkg::*;

    localparam int STEPS = WIDE_BITS + FRAC_BITS + 1;
    localparam int SW    = $clog2(STEPS + 1);
    localparam int QW    = OUT_BITS + 1;
    localparam logic [QW:0] LIM = {{(QW - OUT_BITS + 1){1'b0}}, 1'b1, {(OUT_BITS-1){1'b0}}};

    logic              r_busy;
    logic              r_fin;
    logic              r_neg;
    logic              r_big;
    logic [SW-1:0]     r_cnt;
    t_wide             r_mag;
    t_wide             r_den;
    t_wide             r_rem;
    logic [QW-1:0]     r_q;
    logic [WIDE_BITS:0] rem2;
    logic [WIDE_BITS:0] rem_sub;
    logic              ge;
    t_wide             rem_nx;
    logic [QW:0]       rnd;
    logic [QW:0]       mag_o;
    logic [QW:0]       res;

    // one restoring step
    always_comb begin
        rem2    = {r_rem, r_mag[WIDE_BITS-1]};
        ge      = rem2 >= {1'b0, r_den};
        rem_sub = rem2 - {1'b0, r_den};
        rem_nx  = ge ? rem_sub[WIDE_BITS-1:0] : rem2[WIDE_BITS-1:0];
    end

    // rounding, saturation and sign
    always_comb begin
        rnd = ({1'b0, r_q} + (QW+1)'(1)) >> 1;
        if (r_neg) begin
            mag_o = (r_big || rnd > LIM) ? LIM : rnd;
            res   = (~mag_o) + (QW+1)'(1);
        end else begin
            mag_o = (r_big || rnd > LIM - (QW+1)'(1)) ? LIM - (QW+1)'(1) : rnd;
            res   = mag_o;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[WIDE_BITS-1];
            r_mag <= i_num[WIDE_BITS-1] ? (~i_num) + WIDE_BITS'(1) : i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
            r_cnt <= SW'(STEPS - 1);
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_mag <= r_mag << 1;
            r_q   <= {r_q[QW-2:0], ge};
            r_big <= r_big | r_q[QW-1];
            r_cnt <= r_cnt - SW'(1);
        end else if (r_fin) begin
            o_q <= res[OUT_BITS-1:0];
        end
    end

endmodule

// File: rtl/least_squares_bezier_fit.sv
// least-squares cubic bezier fit of a contour segment, top level
// depends on lsbf_pkg, lsbf_store, lsbf_mul, lsbf_div
//
//  channel  | handshake          | beat contents
//  ---------+--------------------+-------------------------------------------
//  points   | i_valid / o_stall  | i_point_x, i_point_y, i_last_point
//  curve    | o_valid / i_stall  | o_ctrl0_x .. o_ctrl3_y, o_overflow
//
// a point beat is taken whenever the input is not stalled; a last point starts the fit and the
// input stalls until the result is registered.
// per axis, a segment of four points or more takes the setup products and, for
// each inner point, two passes of the shared 8-bit-digit multiplier in the
// weighted sums; segments of two points or more then take two divisions on the
// shared one-bit-per-cycle divider; both axes run one after the other.
// reset is synchronous, active low; no clearing pass. a finished result waits
// in the output register while new points are accepted.

module least_squares_bezier_fit #(
    parameter int MAX_POINTS = lsbf_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = lsbf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lsbf_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic                  i_last_point,
    output logic                  o_valid,
    input  logic                  i_stall,
    output lsbf_pkg::t_out        o_ctrl0_x,
    output lsbf_pkg::t_out        o_ctrl0_y,
    output lsbf_pkg::t_out        o_ctrl1_x,
    output lsbf_pkg::t_out        o_ctrl1_y,
    output lsbf_pkg::t_out        o_ctrl2_x,
    output lsbf_pkg::t_out        o_ctrl2_y,
    output lsbf_pkg::t_out        o_ctrl3_x,
    output lsbf_pkg::t_out        o_ctrl3_y,
    output logic                  o_overflow
);
    import lsbf_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // weight polynomial coefficients
    localparam t_half C_A3  = 15;
    localparam t_half C_A2  = 5;
    localparam t_half C_A1  = 2;
    localparam t_half C_A0  = 4;
    localparam t_half C_B3  = 10;
    localparam t_half C_B2  = 15;
    localparam t_half C_B0  = 2;
    localparam t_half C_LAM = 70;
    localparam t_half C_THREE = 3;
    // forward differences of gamma(k) = 6k^4 - 8nk^3 + 6k^2 - 4nk + n^4 - n^2 at k = 0
    localparam t_half DG1_C = 12;
    localparam t_half DG1_N = 12;
    localparam t_half DG2_C = 96;
    localparam t_half DG2_N = 48;
    localparam t_half DG3_C = 216;
    localparam t_half DG3_N = 48;
    localparam t_half DG4   = 144;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_LD1   = 17'h00002,
        S_LD2   = 17'h00004,
        S_LD3   = 17'h00008,
        S_SMALL = 17'h00010,
        S_OPS   = 17'h00020,
        S_OPW   = 17'h00040,
        S_LINIT = 17'h00080,
        S_SSTEP = 17'h00100,
        S_SM1   = 17'h00200,
        S_SW1   = 17'h00400,
        S_SM2   = 17'h00800,
        S_SW2   = 17'h01000,
        S_DIV   = 17'h02000,
        S_DIVW  = 17'h04000,
        S_AXEND = 17'h08000,
        S_OUTW  = 17'h10000
    } t_state;

    typedef enum logic [3:0] {
        OP_N2, OP_N3, OP_N4, OP_M, OP_D1, OP_D2, OP_AP0, OP_BPN,
        OP_BP0, OP_APN, OP_Q1, OP_Q2, OP_R1, OP_R2
    } t_op;

    t_state  r_state;
    t_op     r_op;
    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_k;
    logic          r_ovf;
    logic          r_axis;
    logic          r_didx;
    logic          r_ovalid;
    logic [COORD_BITS-1:0] r_p0;
    logic [COORD_BITS-1:0] r_pn;
    logic [COORD_BITS-1:0] r_p1;
    t_half r_n2, r_n3, r_n4, r_m;
    t_half r_g, r_d1, r_d2, r_d3;
    t_wide r_den, r_t1, r_t2, r_q1, r_q2, r_s1, r_s2;
    t_out  r_cx [4];
    t_out  r_cy [4];

    logic          in_acc;
    logic          out_acc;
    logic          out_load;
    logic          has_room;
    logic [CW-1:0] cnt_new;
    logic [CW-1:0] k_nx;
    logic          mem_re;
    logic [AW-1:0] raddr_a;
    logic [AW-1:0] raddr_b;
    logic [COORD_BITS-1:0] rd_ax, rd_ay, rd_bx, rd_by;
    logic [COORD_BITS-1:0] rd_a, rd_b;
    t_half nh, a_coef, b_coef, lam, h_p0, h_pn, h_p1;
    logic  mul_start, mul_done, div_start, div_done;
    t_wide mul_a, mul_p, div_num;
    t_half mul_b;
    t_out  div_q;

    function automatic t_half coord_half(input logic [COORD_BITS-1:0] p);
        coord_half = {{(HALF_BITS-COORD_BITS){p[COORD_BITS-1]}}, p};
    endfunction

    function automatic t_wide half_wide(input t_half v);
        half_wide = {{(WIDE_BITS-HALF_BITS){v[HALF_BITS-1]}}, v};
    endfunction

    function automatic t_out coord_out(input logic [COORD_BITS-1:0] p);
        coord_out = {{(OUT_BITS-COORD_BITS){p[COORD_BITS-1]}}, p} << FRAC_BITS;
    endfunction

    // handshakes
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_ovalid && !i_stall;
    assign out_load = (r_state == S_OUTW) && (!r_ovalid || !i_stall);
    assign has_room = (r_cnt < CW'(MAX_POINTS));
    assign cnt_new  = has_room ? r_cnt + CW'(1) : r_cnt;
    assign k_nx     = r_k + CW'(1);

    // derived values of n and the end points
    assign nh     = HALF_BITS'(r_n);
    assign a_coef = (C_A2 * r_n2 + C_A1 * nh + C_A0) - C_A3 * r_n3;
    assign b_coef = (C_B3 * r_n3 + nh + C_B0) - C_B2 * r_n2;
    assign lam    = C_LAM * nh;
    assign h_p0   = coord_half(r_p0);
    assign h_pn   = coord_half(r_pn);
    assign h_p1   = coord_half(r_p1);
    assign rd_a   = r_axis ? rd_ay : rd_ax;
    assign rd_b   = r_axis ? rd_by : rd_bx;

    // store read addresses
    always_comb begin
        mem_re  = 1'b0;
        raddr_a = '0;
        raddr_b = r_n[AW-1:0];
        unique case (r_state)
            S_LD1: begin
                mem_re = 1'b1;
            end
            S_LD2: begin
                mem_re  = 1'b1;
                raddr_a = AW'(1);
            end
            S_SSTEP: begin
                mem_re  = 1'b1;
                raddr_a = k_nx[AW-1:0];
                raddr_b = AW'(r_n - k_nx);
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // multiplier operand selection
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        if (r_state == S_OPS) begin
            mul_start = 1'b1;
            unique case (r_op)
                OP_N2:  begin mul_a = half_wide(nh);            mul_b = nh; end
                OP_N3:  begin mul_a = half_wide(r_n2);          mul_b = nh; end
                OP_N4:  begin mul_a = half_wide(r_n2);          mul_b = r_n2; end
                OP_M:   begin mul_a = half_wide(r_n2 - HALF_BITS'(1));
                              mul_b = nh - HALF_BITS'(2); end
                OP_D1:  begin mul_a = half_wide(C_THREE * r_m); mul_b = nh + HALF_BITS'(2); end
                OP_D2:  begin mul_a = r_den;  mul_b = C_THREE * r_n2 + HALF_BITS'(1); end
                OP_AP0: begin mul_a = half_wide(a_coef); mul_b = h_p0; end
                OP_BPN: begin mul_a = half_wide(b_coef); mul_b = h_pn; end
                OP_BP0: begin mul_a = half_wide(b_coef); mul_b = h_p0; end
                OP_APN: begin mul_a = half_wide(a_coef); mul_b = h_pn; end
                OP_Q1:  begin mul_a = r_t1; mul_b = r_m; end
                OP_Q2:  begin mul_a = r_t2; mul_b = r_m; end
                OP_R1:  begin mul_a = r_s1; mul_b = lam; end
                OP_R2:  begin mul_a = r_s2; mul_b = lam; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == S_SM1) begin
            mul_start = 1'b1;
            mul_a     = half_wide(r_g);
            mul_b     = coord_half(rd_a);
        end else if (r_state == S_SM2) begin
            mul_start = 1'b1;
            mul_a     = half_wide(r_g);
            mul_b     = coord_half(rd_b);
        end
    end

    assign div_start = (r_state == S_DIV);
    assign div_num   = r_didx ? r_q2 : r_q1;

    // result valid flag: set when a fit loads the output, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (out_acc) begin
            r_ovalid <= 1'b0;
        end
    end

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_drop   <= 1'b0;
            r_axis   <= 1'b0;
            r_didx   <= 1'b0;
            r_op     <= OP_N2;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_last_point) begin
                            r_n     <= cnt_new - CW'(1);
                            r_ovf   <= r_drop | ~has_room;
                            r_cnt   <= '0;
                            r_drop  <= 1'b0;
                            r_axis  <= 1'b0;
                            r_state <= S_LD1;
                        end else begin
                            r_cnt  <= cnt_new;
                            r_drop <= r_drop | ~has_room;
                        end
                    end
                end
                S_LD1: begin
                    r_state <= S_LD2;
                end
                S_LD2: begin
                    r_p0    <= rd_a;
                    r_pn    <= rd_b;
                    r_state <= S_LD3;
                end
                S_LD3: begin
                    r_p1   <= rd_a;
                    r_didx <= 1'b0;
                    if (r_n == '0) begin
                        r_state <= S_AXEND;
                    end else if (r_n < CW'(3)) begin
                        r_state <= S_SMALL;
                    end else begin
                        r_op    <= OP_N2;
                        r_state <= S_OPS;
                    end
                end
                S_SMALL: begin
                    r_state <= S_DIV;
                end
                S_OPS: begin
                    r_state <= S_OPW;
                end
                S_OPW: begin
                    if (mul_done) begin
                        if (r_op == OP_Q2) begin
                            r_op    <= OP_R1;
                            r_state <= S_LINIT;
                        end else if (r_op == OP_R2) begin
                            r_didx  <= 1'b0;
                            r_state <= S_DIV;
                        end else begin
                            r_op    <= t_op'(r_op + 4'd1);
                            r_state <= S_OPS;
                        end
                    end
                end
                S_LINIT: begin
                    r_k     <= '0;
                    r_state <= S_SSTEP;
                end
                S_SSTEP: begin
                    if (r_k == r_n - CW'(1)) begin
                        r_state <= S_OPS;
                    end else begin
                        r_k     <= k_nx;
                        r_state <= S_SM1;
                    end
                end
                S_SM1: begin
                    r_state <= S_SW1;
                end
                S_SW1: begin
                    if (mul_done) begin
                        r_state <= S_SM2;
                    end
                end
                S_SM2: begin
                    r_state <= S_SW2;
                end
                S_SW2: begin
                    if (mul_done) begin
                        r_state <= S_SSTEP;
                    end
                end
                S_DIV: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        if (!r_didx) begin
                            r_didx  <= 1'b1;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_AXEND;
                        end
                    end
                end
                S_AXEND: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= S_LD1;
                    end else begin
                        r_state <= S_OUTW;
                    end
                end
                S_OUTW: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SMALL: begin
                r_den <= half_wide(C_THREE);
                if (r_n == CW'(1)) begin
                    r_q1 <= half_wide((h_p0 << 1) + h_pn);
                    r_q2 <= half_wide(h_p0 + (h_pn << 1));
                end else begin
                    r_q1 <= half_wide((h_p1 << 2) - h_pn);
                    r_q2 <= half_wide((h_p1 << 2) - h_p0);
                end
            end
            S_OPW: begin
                if (mul_done) begin
                    case (r_op)
                        OP_N2:  r_n2  <= mul_p[HALF_BITS-1:0];
                        OP_N3:  r_n3  <= mul_p[HALF_BITS-1:0];
                        OP_N4:  r_n4  <= mul_p[HALF_BITS-1:0];
                        OP_M:   r_m   <= mul_p[HALF_BITS-1:0];
                        OP_D1:  r_den <= mul_p;
                        OP_D2:  r_den <= mul_p;
                        OP_AP0: r_t1  <= mul_p;
                        OP_BPN: r_t1  <= r_t1 + mul_p;
                        OP_BP0: r_t2  <= mul_p;
                        OP_APN: r_t2  <= r_t2 + mul_p;
                        OP_Q1:  r_q1  <= mul_p;
                        OP_Q2:  r_q2  <= mul_p;
                        OP_R1:  r_q1  <= r_q1 + mul_p;
                        OP_R2:  r_q2  <= r_q2 + mul_p;
                        default: r_q1 <= r_q1;
                    endcase
                end
            end
            S_LINIT: begin
                r_g  <= r_n4 - r_n2;
                r_d1 <= DG1_C - DG1_N * nh;
                r_d2 <= DG2_C - DG2_N * nh;
                r_d3 <= DG3_C - DG3_N * nh;
                r_s1 <= '0;
                r_s2 <= '0;
            end
            S_SSTEP: begin
                // gamma(k) advances by forward differences
                r_g  <= r_g + r_d1;
                r_d1 <= r_d1 + r_d2;
                r_d2 <= r_d2 + r_d3;
                r_d3 <= r_d3 + DG4;
            end
            S_SW1: begin
                if (mul_done) begin
                    r_s1 <= r_s1 + mul_p;
                end
            end
            S_SW2: begin
                if (mul_done) begin
                    r_s2 <= r_s2 + mul_p;
                end
            end
            default: begin
                r_g <= r_g;
            end
        endcase
    end

    // control point results per axis
    always_ff @(posedge i_clk) begin
        if (r_state == S_LD3) begin
            if (r_axis) begin
                r_cy[0] <= coord_out(r_p0);
                r_cy[1] <= coord_out(r_p0);
                r_cy[2] <= coord_out(r_p0);
                r_cy[3] <= coord_out(r_pn);
            end else begin
                r_cx[0] <= coord_out(r_p0);
                r_cx[1] <= coord_out(r_p0);
                r_cx[2] <= coord_out(r_p0);
                r_cx[3] <= coord_out(r_pn);
            end
        end else if (r_state == S_DIVW && div_done) begin
            if (r_axis) begin
                if (r_didx) r_cy[2] <= div_q;
                else        r_cy[1] <= div_q;
            end else begin
                if (r_didx) r_cx[2] <= div_q;
                else        r_cx[1] <= div_q;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_ctrl0_x  <= r_cx[0];
            o_ctrl0_y  <= r_cy[0];
            o_ctrl1_x  <= r_cx[1];
            o_ctrl1_y  <= r_cy[1];
            o_ctrl2_x  <= r_cx[2];
            o_ctrl2_y  <= r_cy[2];
            o_ctrl3_x  <= r_cx[3];
            o_ctrl3_y  <= r_cy[3];
            o_overflow <= r_ovf;
        end
    end

    lsbf_store #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (in_acc && has_room),
        .i_waddr   (r_cnt[AW-1:0]),
        .i_wx      (i_point_x),
        .i_wy      (i_point_y),
        .i_re      (mem_re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_ax      (rd_ax),
        .o_ay      (rd_ay),
        .o_bx      (rd_bx),
        .o_by      (rd_by)
    );

    lsbf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    lsbf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

endmodule

// File: rtl/lsbf_checker.sv
// port-level checks for the bezier fit top level, attached by bind
// depends on lsbf_pkg and least_squares_bezier_fit

module lsbf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input logic           i_last_point,
    input logic           o_valid,
    input logic           i_stall,
    input lsbf_pkg::t_out o_ctrl1_x,
    input lsbf_pkg::t_out o_ctrl2_y,
    input logic           o_overflow
);

    // a stalled result beat stays and holds ctrl1_x, ctrl2_y and the overflow flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ctrl1_x) && $stable(o_ctrl2_y)
            && $stable(o_overflow))
        else $error("result beat changed while stalled");

    // a last point starts the fit, so the input stalls on the next cycle
    a_fit_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_point |=> o_stall)
        else $error("input not stalled after last point");

    // a new result only appears at the end of a fit
    a_result_after_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat without a fit");

endmodule

bind least_squares_bezier_fit lsbf_checker u_lsbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_last_point (i_last_point),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_ctrl1_x    (o_ctrl1_x),
    .o_ctrl2_y    (o_ctrl2_y),
    .o_overflow   (o_overflow)
);

// File: tb/sv/testbench.sv
// self-checking testbench for least_squares_bezier_fit: contour segments in, control points out
// depends on lsbf_pkg and the rtl of the block; predicts each fit with exact wide arithmetic
`timescale 1ns / 1ps

module testbench;
    import lsbf_pkg::*;

    localparam int NPTS  = 256;
    localparam int FRAC  = 16;
    localparam int NITEMS = 850;

    typedef logic signed [191:0] t_big;

    typedef struct {
        t_out ctrl [8];
        logic ovf;
    } t_curve;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               typed;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [15:0] i_point_x = '0;
    logic [15:0] i_point_y = '0;
    logic i_last_point = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_ctrl0_x, o_ctrl0_y, o_ctrl1_x, o_ctrl1_y;
    t_out o_ctrl2_x, o_ctrl2_y, o_ctrl3_x, o_ctrl3_y;
    logic o_overflow;

    least_squares_bezier_fit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_last_point(i_last_point),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_ctrl0_x(o_ctrl0_x), .o_ctrl0_y(o_ctrl0_y),
        .o_ctrl1_x(o_ctrl1_x), .o_ctrl1_y(o_ctrl1_y),
        .o_ctrl2_x(o_ctrl2_x), .o_ctrl2_y(o_ctrl2_y),
        .o_ctrl3_x(o_ctrl3_x), .o_ctrl3_y(o_ctrl3_y),
        .o_overflow(o_overflow)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: point store of the open segment
    int     seg_x [NPTS];
    int     seg_y [NPTS];
    int     seg_count = 0;
    logic   seg_dropped = 1'b0;
    t_curve curves_due [$];
    t_point points [$];
    int     mismatches = 0;
    int     curves_seen = 0;
    int     ovf_seen = 0;
    int     long_segs = 0;
    bit     send_done = 0;

    // round(num * 2^FRAC / den), ties away from zero, saturated to 48 bits
    function automatic t_out to_fixed(t_big num, t_big den);
        t_big mag;
        t_big q;
        t_big lim;
        logic neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag <<< (FRAC + 1)) / den;
        q = (q + 1) >>> 1;
        lim = t_big'(1) <<< 47;
        if (neg) begin
            if (q > lim) q = lim;
            return t_out'(-q);
        end
        if (q > lim - 1) q = lim - 1;
        return t_out'(q);
    endfunction

    function automatic longint weight(longint k, longint n);
        longint k2, n2;
        k2 = k * k;
        n2 = n * n;
        return 6*k2*k2 - 8*n*k2*k + 6*k2 - 4*n*k + n2*n2 - n2;
    endfunction

    // control points of one axis over stored coordinates v[0..n]
    function automatic void fit_axis(input int v [NPTS], input int n, output t_out c [4]);
        longint p0, pn, n2, n3, a, b, m;
        t_big s1, s2, num1, num2, den;
        p0 = v[0];
        pn = v[n];
        c[0] = to_fixed(t_big'(p0), t_big'(1));
        c[3] = to_fixed(t_big'(pn), t_big'(1));
        if (n == 0) begin
            c[1] = c[0];
            c[2] = c[0];
        end else if (n == 1) begin
            c[1] = to_fixed(t_big'(2*p0 + pn), t_big'(3));
            c[2] = to_fixed(t_big'(p0 + 2*pn), t_big'(3));
        end else if (n == 2) begin
            c[1] = to_fixed(t_big'(4*longint'(v[1]) - pn), t_big'(3));
            c[2] = to_fixed(t_big'(4*longint'(v[1]) - p0), t_big'(3));
        end else begin
            n2 = n * n;
            n3 = n2 * n;
            a = -15*n3 + 5*n2 + 2*n + 4;
            b = 10*n3 - 15*n2 + n + 2;
            m = (n - 1) * (n + 1) * (n - 2);
            s1 = 0;
            s2 = 0;
            for (int i = 1; i < n; i++) begin
                s1 += t_big'(weight(i, n)) * t_big'(longint'(v[i]));
                s2 += t_big'(weight(n - i, n)) * t_big'(longint'(v[i]));
            end
            num1 = (t_big'(a)*t_big'(p0) + t_big'(b)*t_big'(pn)) * t_big'(m)
                   + t_big'(70*n) * s1;
            num2 = (t_big'(b)*t_big'(p0) + t_big'(a)*t_big'(pn)) * t_big'(m)
                   + t_big'(70*n) * s2;
            den = t_big'(3*m) * t_big'(n + 2) * t_big'(3*n2 + 1);
            c[1] = to_fixed(num1, den);
            c[2] = to_fixed(num2, den);
        end
    endfunction

    // take one accepted point beat into the predictor
    task automatic take_point(t_point p);
        t_curve cv;
        t_out cx [4];
        t_out cy [4];
        if (seg_count < NPTS) begin
            seg_x[seg_count] = int'(p.x);
            seg_y[seg_count] = int'(p.y);
            seg_count++;
        end else begin
            seg_dropped = 1'b1;
        end
        if (p.last) begin
            fit_axis(seg_x, seg_count - 1, cx);
            fit_axis(seg_y, seg_count - 1, cy);
            for (int k = 0; k < 4; k++) begin
                cv.ctrl[2*k]   = cx[k];
                cv.ctrl[2*k+1] = cy[k];
            end
            cv.ovf = seg_dropped;
            // single-point segments: every control point is the point itself
            if (p.typed) begin
                for (int k = 0; k < 4; k++) begin
                    cv.ctrl[2*k]   = {{16{p.x[15]}}, p.x, 16'h0};
                    cv.ctrl[2*k+1] = {{16{p.y[15]}}, p.y, 16'h0};
                end
                cv.ovf = 1'b0;
            end
            if (seg_count > 40) long_segs++;
            curves_due.push_back(cv);
            seg_count = 0;
            seg_dropped = 1'b0;
        end
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_point mk(int x, int y, logic last, logic typed);
        t_point p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.last = last;
        p.typed = typed;
        return p;
    endfunction

    // stimulus: directed table, then random segments
    initial begin
        int len;
        int total;
        t_point tbl [$];
        tbl = '{
            mk(32767, -32768, 1, 1), mk(-32768, 32767, 1, 1), mk(0, 0, 1, 1),
            mk(-1, -1, 1, 1),
            mk(100, -5, 0, 0), mk(-7, 3, 1, 0),
            mk(32767, 32767, 0, 0), mk(-32768, 0, 0, 0), mk(32767, -32768, 1, 0),
            mk(0, 5, 0, 0), mk(10, 20, 0, 0), mk(-30, 40, 0, 0), mk(50, -60, 1, 0),
            mk(-32768, -32768, 0, 0), mk(32767, 32767, 0, 0), mk(-32768, 32767, 0, 0),
            mk(32767, -32768, 0, 0), mk(-32768, -32768, 1, 0)
        };
        foreach (tbl[i]) points.push_back(tbl[i]);
        total = points.size();
        while (total < NITEMS) begin
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(250, 262);
                1, 2, 3: len = $urandom_range(11, 40);
                default: len = $urandom_range(1, 10);
            endcase
            for (int i = 0; i < len; i++)
                points.push_back(mk(rand_coord(), rand_coord(), i == len - 1, 0));
            total += len;
        end
    end

    // point sender: bursts with random gaps
    initial begin
        int burst;
        t_point p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst = $urandom_range(1, 30);
        while (points.size() > 0) begin
            p = points.pop_front();
            i_valid      <= 1'b1;
            i_point_x    <= p.x;
            i_point_y    <= p.y;
            i_last_point <= p.last;
            do @(negedge i_clk); while (o_stall);
            take_point(p);
            @(posedge i_clk);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
            end
        end
        i_valid <= 1'b0;
        send_done = 1;
    end

    // curve receiver: stall pattern changes every stretch, one long hold-off
    initial begin
        int mode;
        int cyc;
        cyc = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 200 == 0) mode = $urandom_range(0, 2);
            if (cyc >= 20000 && cyc < 23000)
                i_stall <= 1'b1;
            else if (mode == 0)
                i_stall <= 1'b0;
            else if (mode == 1)
                i_stall <= ($urandom_range(0, 9) < 3);
            else
                i_stall <= ($urandom_range(0, 9) < 8);
        end
    end

    // curve checker: compare each accepted beat with the oldest prediction
    always @(negedge i_clk) begin
        t_curve want;
        t_out got [8];
        bit bad;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_ctrl0_x, o_ctrl0_y, o_ctrl1_x, o_ctrl1_y,
                    o_ctrl2_x, o_ctrl2_y, o_ctrl3_x, o_ctrl3_y};
            curves_seen++;
            if (o_overflow) ovf_seen++;
            if (curves_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected curve beat at %0t", $realtime);
            end else begin
                want = curves_due.pop_front();
                bad = 0;
                for (int k = 0; k < 8; k++) begin
                    if (got[k] !== want.ctrl[k]) begin
                        bad = 1;
                        if (mismatches < 10)
                            $display("ctrl%0d_%s: expected %h got %h", k / 2,
                                     (k % 2) ? "y" : "x", want.ctrl[k], got[k]);
                    end
                end
                if (o_overflow !== want.ovf) begin
                    bad = 1;
                    if (mismatches < 10)
                        $display("overflow: expected %b got %b", want.ovf, o_overflow);
                end
                if (bad) mismatches++;
            end
        end
    end

    // end of run
    initial begin
        wait (send_done);
        wait (curves_due.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("checked %0d curves, %0d with dropped points, %0d segments over 40 points",
                 curves_seen, ovf_seen, long_segs);
        if (mismatches == 0 && curves_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial begin
        #100_000_000;
        $display("timeout, %0d curves still due", curves_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
